// File: src/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

// File: src/snrf_pkg.sv
// Package: constants and shared types of the safeguarded Newton root finder
`timescale 1ns / 1ps
package snrf_pkg;
    localparam int XW = 32;
    localparam int TOL_W = 31;
    localparam int LIM_W = 16;
    localparam int DIV_CNT_W = 6;
    localparam int DIV_STEPS = 48;

    localparam logic [0:0] CFG_TOLERANCE = 1'b0;
    localparam logic [0:0] CFG_ITER_LIMIT = 1'b1;
    localparam logic [0:0] OP_START = 1'b0;
    localparam logic [0:0] OP_EVAL = 1'b1;

    localparam logic [1:0] ST_EXACT = 2'd0;
    localparam logic [1:0] ST_NO_SIGN = 2'd1;
    localparam logic [1:0] ST_CONVERGED = 2'd2;
    localparam logic [1:0] ST_LIMIT = 2'd3;

    localparam logic [31:0] TOL_RESET = 32'd66;
    localparam logic [31:0] LIM_RESET = 32'd100;

    // request to and answer from the serial divider
    typedef struct packed {
        logic        start;
        logic [47:0] dividend_mag;
        logic [31:0] divisor_mag;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [47:0] quotient;
    } div_rsp_t;
endpackage

// File: src/snrf_divider.sv
// Restoring serial divider: one quotient bit per cycle, unsigned magnitudes
`timescale 1ns / 1ps
`include "assert_macros.svh"
module snrf_divider
    import snrf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;
    logic [33:0] diff;

    // one shift-subtract step
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[31:0], quo_reg[47]};
        diff = {1'b0, trial} - {2'b00, dsr_reg};
        if (req.start) begin
            quo_next = req.dividend_mag;
            rem_next = '0;
            dsr_next = req.divisor_mag;
            cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[33]) begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        if (!aresetn) begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quotient = quo_reg;

    `ASSERT_CLK(a_done_after_busy, aclk, aresetn, rsp.done |-> $past(busy_reg))
    `ASSERT_CLK(a_no_done_and_busy, aclk, aresetn, !(rsp.done && rsp.busy))
    `ASSERT_CLK(a_start_busy, aclk, aresetn, req.start |=> busy_reg)
endmodule

// File: src/safeguarded_newton_root_finder.sv
// Top level: bracketed Newton root finder with bisection fallback, Q16.16
//
//  channel | ports                                     | dir
//  input   | s_valid s_ready s_op s_low_end ...        | in
//  result  | m_valid m_ready m_finished m_point_x ...  | out
//  config  | cfg_we cfg_index cfg_data                 | in
//
// A start or a low-end evaluation shows its result in the cycle after the transfer,
// a high-end evaluation after the end-point classification state. A refinement
// evaluation that hits the limit check answers in the cycle after the transfer;
// else three products on one shared 33x33 multiplier, then, unless it bisects, a
// serial divider for the Newton quotient until its done flag, then the step update.
// The input is not ready while an item is in work or a result waits.
// Reset is synchronous, active low, and restores the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module safeguarded_newton_root_finder
    import snrf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [31:0] s_low_end,
    input  logic signed [31:0] s_high_end,
    input  logic signed [31:0] s_eval_y,
    input  logic signed [31:0] s_eval_dy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_finished,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_answer_y,
    output logic signed [31:0] m_answer_dy,
    output logic [1:0]         m_status
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT_LOW = 2'd1;
    localparam logic [1:0] PH_WAIT_HIGH = 2'd2;
    localparam logic [1:0] PH_ITERATE = 2'd3;

    localparam logic [2:0] SQ_IDLE = 3'd0;
    localparam logic [2:0] SQ_MUL_A = 3'd1;
    localparam logic [2:0] SQ_MUL_B = 3'd2;
    localparam logic [2:0] SQ_MUL_C = 3'd3;
    localparam logic [2:0] SQ_DIV = 3'd4;
    localparam logic [2:0] SQ_FINISH = 3'd5;
    localparam logic [2:0] SQ_OUT = 3'd6;

    logic [TOL_W-1:0] tol_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [1:0] phase_reg;
    logic [2:0] sq_reg;
    logic signed [31:0] start_low_reg, start_high_reg, low_y_reg, low_dy_reg;
    logic signed [31:0] neg_reg, pos_reg, cur_x_reg, y_reg, dy_reg;
    logic signed [31:0] step_reg, prev_reg;
    logic [LIM_W-1:0] cnt_reg;
    logic signed [32:0] da_reg;
    logic signed [65:0] pa_reg, pb_reg;
    logic [65:0] pc_reg;
    logic ov_valid_reg, ov_fin_reg;
    logic signed [31:0] ov_x_reg, ov_y_reg, ov_dy_reg;
    logic [1:0] ov_st_reg;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    div_req_t div_req;
    div_rsp_t div_rsp;
    snrf_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    logic s_fire;
    assign s_ready = (sq_reg == SQ_IDLE) && !ov_valid_reg;
    assign s_fire = s_valid && s_ready;

    logic signed [65:0] q_ext;
    logic signed [31:0] y_in, dy_in;
    assign y_in = s_eval_y;
    assign dy_in = s_eval_dy;
    assign q_ext = 66'(y_reg) <<< 16;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = 33'(cur_x_reg) - 33'(pos_reg);
        mul_b = 33'(dy_reg);
        unique case (sq_reg)
            SQ_MUL_A: begin
                mul_a = 33'(cur_x_reg) - 33'(pos_reg);
                mul_b = 33'(dy_reg);
            end
            SQ_MUL_B: begin
                mul_a = 33'(cur_x_reg) - 33'(neg_reg);
                mul_b = 33'(dy_reg);
            end
            SQ_MUL_C: begin
                mul_a = prev_reg[31] ? -33'(prev_reg) : 33'(prev_reg);
                mul_b = dy_reg[31] ? -33'(dy_reg) : 33'(dy_reg);
            end
            default: begin
                mul_a = da_reg;
                mul_b = 33'(dy_reg);
            end
        endcase
    end

    // signs, tests and step results
    logic signed [1:0] sa, sb;
    logic bisect_w;
    logic [32:0] ymag;
    logic [65:0] ymag2;
    logic signed [32:0] half_w;
    logic signed [33:0] newx_w;
    logic signed [48:0] q_signed;
    logic signed [31:0] nstep, nx;
    logic [32:0] nstep_mag;
    always_comb begin
        sa = (pa_reg > q_ext) ? 2'sd1 : ((pa_reg < q_ext) ? -2'sd1 : 2'sd0);
        sb = (pb_reg > q_ext) ? 2'sd1 : ((pb_reg < q_ext) ? -2'sd1 : 2'sd0);
        ymag = y_reg[31] ? -33'(y_reg) : 33'(y_reg);
        ymag2 = 66'(ymag) << 17;
        bisect_w = (dy_reg == 0) || ((sa * sb) > 0) || (ymag2 > pc_reg);
        half_w = (33'(pos_reg) - 33'(neg_reg)) >>> 1;
        q_signed = (y_reg[31] ^ dy_reg[31]) ? -49'(div_rsp.quotient)
                                            : 49'(div_rsp.quotient);
        if (bisect_w) begin
            nstep = half_w[31:0];
            newx_w = 34'(neg_reg) + 34'(half_w);
        end else begin
            if (q_signed > 49'sh7FFFFFFF) nstep = 32'sh7FFFFFFF;
            else if (q_signed < -49'sh80000000) nstep = -32'sh80000000;
            else nstep = q_signed[31:0];
            newx_w = 34'(cur_x_reg) - 34'(nstep);
        end
        if (newx_w > 34'sh7FFFFFFF) nx = 32'sh7FFFFFFF;
        else if (newx_w < -34'sh80000000) nx = -32'sh80000000;
        else nx = newx_w[31:0];
        nstep_mag = nstep[31] ? -33'(nstep) : 33'(nstep);
    end

    logic bisect_pre;
    assign bisect_pre = (dy_reg == 0) || ((sa * sb) > 0) || (ymag2 > 66'(mul_p));
    assign div_req.start = (sq_reg == SQ_MUL_C) && !bisect_pre;
    assign div_req.dividend_mag = {ymag[31:0], 16'd0};
    assign div_req.divisor_mag = dy_reg[31] ? -dy_reg : dy_reg;

    // start-time helpers
    logic signed [32:0] sum_w, diff_w;
    logic signed [31:0] mid_w, istep_w;
    assign sum_w = 33'(start_low_reg) + 33'(start_high_reg);
    assign mid_w = sum_w[32:1];
    assign diff_w = 33'(start_high_reg) - 33'(start_low_reg);
    assign istep_w = (diff_w > 33'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                     (diff_w < -33'sh80000000) ? -32'sh80000000 : diff_w[31:0];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET[TOL_W-1:0];
            lim_reg <= LIM_RESET[LIM_W-1:0];
        end else if (cfg_we) begin
            if (cfg_index == CFG_TOLERANCE) tol_reg <= cfg_data[TOL_W-1:0];
            else lim_reg <= cfg_data[LIM_W-1:0];
        end
    end

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            sq_reg <= SQ_IDLE;
            ov_valid_reg <= 1'b0;
            start_low_reg <= '0; start_high_reg <= '0;
            low_y_reg <= '0; low_dy_reg <= '0;
            neg_reg <= '0; pos_reg <= '0; cur_x_reg <= '0;
            y_reg <= '0; dy_reg <= '0; step_reg <= '0; prev_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (ov_valid_reg && m_ready) ov_valid_reg <= 1'b0;
            unique case (sq_reg)
                SQ_IDLE: begin
                    if (s_fire) begin
                        if (s_op == OP_START) begin
                            start_low_reg <= s_low_end;
                            start_high_reg <= s_high_end;
                            phase_reg <= PH_WAIT_LOW;
                            ov_valid_reg <= 1'b1; ov_fin_reg <= 1'b0;
                            ov_x_reg <= s_low_end; ov_y_reg <= '0;
                            ov_dy_reg <= '0; ov_st_reg <= ST_EXACT;
                        end else if (phase_reg == PH_WAIT_LOW) begin
                            low_y_reg <= y_in; low_dy_reg <= dy_in;
                            phase_reg <= PH_WAIT_HIGH;
                            ov_valid_reg <= 1'b1; ov_fin_reg <= 1'b0;
                            ov_x_reg <= start_high_reg; ov_y_reg <= '0;
                            ov_dy_reg <= '0; ov_st_reg <= ST_EXACT;
                        end else if (phase_reg == PH_WAIT_HIGH) begin
                            y_reg <= y_in; dy_reg <= dy_in;
                            sq_reg <= SQ_FINISH;
                        end else if (phase_reg == PH_ITERATE) begin
                            y_reg <= y_in; dy_reg <= dy_in;
                            if (cnt_reg != 0) begin
                                if (y_in[31]) neg_reg <= cur_x_reg;
                                else pos_reg <= cur_x_reg;
                            end
                            if (cnt_reg >= lim_reg) begin
                                phase_reg <= PH_IDLE;
                                ov_valid_reg <= 1'b1; ov_fin_reg <= 1'b1;
                                ov_x_reg <= cur_x_reg; ov_y_reg <= y_in;
                                ov_dy_reg <= dy_in; ov_st_reg <= ST_LIMIT;
                            end else begin
                                sq_reg <= SQ_MUL_A;
                            end
                        end
                    end
                end
                SQ_MUL_A: begin
                    pa_reg <= mul_p;
                    sq_reg <= SQ_MUL_B;
                end
                SQ_MUL_B: begin
                    pb_reg <= mul_p;
                    sq_reg <= SQ_MUL_C;
                end
                SQ_MUL_C: begin
                    pc_reg <= 66'(mul_p);
                    sq_reg <= bisect_pre ? SQ_OUT : SQ_DIV;
                end
                SQ_DIV: begin
                    if (div_rsp.done) sq_reg <= SQ_OUT;
                end
                SQ_OUT: begin
                    prev_reg <= step_reg;
                    step_reg <= nstep;
                    sq_reg <= SQ_IDLE;
                    ov_valid_reg <= 1'b1;
                    if (nstep_mag < 33'(tol_reg)) begin
                        phase_reg <= PH_IDLE;
                        ov_fin_reg <= 1'b1; ov_x_reg <= cur_x_reg;
                        ov_y_reg <= y_reg; ov_dy_reg <= dy_reg;
                        ov_st_reg <= ST_CONVERGED;
                    end else begin
                        cur_x_reg <= nx;
                        cnt_reg <= cnt_reg + 1'b1;
                        ov_fin_reg <= 1'b0; ov_x_reg <= nx;
                        ov_y_reg <= '0; ov_dy_reg <= '0; ov_st_reg <= ST_EXACT;
                    end
                end
                SQ_FINISH: begin
                    // end-point classification after the high-end value
                    sq_reg <= SQ_IDLE;
                    ov_valid_reg <= 1'b1;
                    ov_fin_reg <= 1'b1;
                    phase_reg <= PH_IDLE;
                    if (low_y_reg == 0) begin
                        ov_x_reg <= start_low_reg; ov_y_reg <= low_y_reg;
                        ov_dy_reg <= low_dy_reg; ov_st_reg <= ST_EXACT;
                    end else if (y_reg == 0) begin
                        ov_x_reg <= start_high_reg; ov_y_reg <= y_reg;
                        ov_dy_reg <= dy_reg; ov_st_reg <= ST_EXACT;
                    end else if (low_y_reg[31] == y_reg[31]) begin
                        ov_st_reg <= ST_NO_SIGN;
                        if (low_y_reg > y_reg) begin
                            if (y_reg[31]) begin
                                ov_x_reg <= start_low_reg; ov_y_reg <= low_y_reg;
                                ov_dy_reg <= low_dy_reg;
                            end else begin
                                ov_x_reg <= start_high_reg; ov_y_reg <= y_reg;
                                ov_dy_reg <= dy_reg;
                            end
                        end else if (y_reg[31]) begin
                            ov_x_reg <= start_high_reg; ov_y_reg <= y_reg;
                            ov_dy_reg <= dy_reg;
                        end else begin
                            ov_x_reg <= start_low_reg; ov_y_reg <= low_y_reg;
                            ov_dy_reg <= low_dy_reg;
                        end
                    end else begin
                        phase_reg <= PH_ITERATE;
                        if (low_y_reg[31]) begin
                            neg_reg <= start_low_reg; pos_reg <= start_high_reg;
                        end else begin
                            neg_reg <= start_high_reg; pos_reg <= start_low_reg;
                        end
                        cur_x_reg <= mid_w;
                        step_reg <= istep_w;
                        prev_reg <= istep_w;
                        cnt_reg <= '0;
                        ov_fin_reg <= 1'b0; ov_x_reg <= mid_w;
                        ov_y_reg <= '0; ov_dy_reg <= '0; ov_st_reg <= ST_EXACT;
                    end
                end
                default: sq_reg <= SQ_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        da_reg <= 33'(cur_x_reg);
    end

    assign m_valid = ov_valid_reg;
    assign m_finished = ov_fin_reg;
    assign m_point_x = ov_x_reg;
    assign m_answer_y = ov_y_reg;
    assign m_answer_dy = ov_dy_reg;
    assign m_status = ov_st_reg;

    `ASSERT_CLK(a_busy_not_ready, aclk, aresetn, (sq_reg != SQ_IDLE) |-> !s_ready)
    `ASSERT_CLK(a_div_only_in_div, aclk, aresetn, div_rsp.busy |-> (sq_reg == SQ_DIV))
    `ASSERT_CLK(a_req_zero_y, aclk, aresetn, (m_valid && !m_finished) |-> (m_answer_y == 0))
    `ASSERT_CLK(a_req_zero_st, aclk, aresetn, (m_valid && !m_finished) |-> (m_status == ST_EXACT))
endmodule
